### sv/tthd_pkg.sv
// Shared types and constants for the touchpad tap/hold detector.
// Used by tthd_engine and touchpad_tap_hold_detector_core; no dependencies.
`timescale 1ns / 1ps

package tthd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_TAP  = 2'd1,
    ST_HOLD = 2'd2,
    ST_CONT = 2'd3
  } state_e;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_NEWTAP      = 3'd1,
    EV_TIMEOUT     = 3'd2,
    EV_FIN         = 3'd3,
    EV_FOUT        = 3'd4,
    EV_TAPHOLD     = 3'd5,
    EV_CONTTIMEOUT = 3'd6
  } event_e;

  // Register indexes on the configuration port
  localparam logic REG_TAP_TIMEOUT  = 1'b0;
  localparam logic REG_HOLD_TIMEOUT = 1'b1;

  localparam logic [15:0] TAP_TIMEOUT_RST  = 16'd200;
  localparam logic [15:0] HOLD_TIMEOUT_RST = 16'd0;

  localparam int unsigned InWidth  = 40;
  localparam int unsigned OutWidth = 72;

  typedef struct packed {
    logic        single_tap;
    logic        native_hold;
    logic        one_finger;
    logic [31:0] now_ms;
  } sample_t;

  typedef struct packed {
    logic        press_key;
    logic        release_key;
    logic        double_tap;
    state_e      machine_state;
    logic        tap_deadline_valid;
    logic [31:0] tap_deadline;
    logic        hold_deadline_valid;
    logic [31:0] hold_deadline;
  } result_t;

endpackage

### sv/tthd_engine.sv
// Tap/hold engine: detector state, event priority select and the four-state machine.
// Depends on tthd_pkg. Steps once per cycle in which step_en_i is high.
`timescale 1ns / 1ps

module tthd_engine import tthd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_en_i,
  input  sample_t     sample_i,
  input  logic [15:0] tap_timeout_i,
  input  logic [15:0] hold_timeout_i,
  output result_t     result_o
);

  state_e      state_q, state_d;
  logic [31:0] tap_start_q, tap_start_d;
  logic [31:0] hold_start_q, hold_start_d;
  logic        prev_one_q, prev_one_d;
  logic        prev_tap_q, prev_tap_d;
  logic        prev_hold_q, prev_hold_d;
  logic        tap_on_q, tap_on_d;
  logic        hold_on_q, hold_on_d;

  logic        active;
  logic [31:0] tap_elapsed, hold_elapsed;
  logic        tap_expired, hold_expired;
  event_e      ev;
  logic        act_timer, act_press, act_release, act_double, act_cont;
  logic [31:0] tap_dl, hold_dl;

  assign active       = sample_i.single_tap | sample_i.native_hold | (state_q != ST_IDLE);
  assign tap_elapsed  = sample_i.now_ms - tap_start_q;
  assign hold_elapsed = sample_i.now_ms - hold_start_q;
  assign tap_expired  = tap_on_q  && (tap_elapsed  >= {16'd0, tap_timeout_i});
  assign hold_expired = hold_on_q && (hold_elapsed >= {16'd0, hold_timeout_i});

  // Pick one event, highest priority first
  always_comb begin
    priority if (!active) begin
      ev = EV_NONE;
    end else if (!prev_tap_q && sample_i.single_tap) begin
      ev = EV_NEWTAP;
    end else if (!prev_hold_q && sample_i.native_hold) begin
      ev = EV_TAPHOLD;
    end else if (prev_one_q != sample_i.one_finger) begin
      ev = prev_one_q ? EV_FOUT : EV_FIN;
    end else if (tap_expired) begin
      ev = EV_TIMEOUT;
    end else if (hold_expired) begin
      ev = EV_CONTTIMEOUT;
    end else begin
      ev = EV_NONE;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ev == EV_NEWTAP) state_d = ST_TAP;
        else if (ev == EV_TAPHOLD) state_d = ST_HOLD;
      end
      ST_TAP: begin
        if (ev == EV_TIMEOUT) state_d = ST_IDLE;
        else if (ev == EV_TAPHOLD || ev == EV_FIN) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (ev == EV_NEWTAP) state_d = ST_TAP;
        else if (ev == EV_FOUT) state_d = (hold_timeout_i == 16'd0) ? ST_IDLE : ST_CONT;
      end
      ST_CONT: begin
        if (ev == EV_NEWTAP) state_d = ST_TAP;
        else if (ev == EV_TAPHOLD || ev == EV_FIN) state_d = ST_HOLD;
        else if (ev == EV_CONTTIMEOUT) state_d = ST_IDLE;
      end
      default: state_d = state_q;
    endcase
  end

  // Actions
  always_comb begin
    act_timer   = 1'b0;
    act_press   = 1'b0;
    act_release = 1'b0;
    act_double  = 1'b0;
    act_cont    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        act_timer = (ev == EV_NEWTAP);
        act_press = (ev == EV_NEWTAP) || (ev == EV_TAPHOLD);
      end
      ST_TAP: begin
        act_timer   = (ev == EV_NEWTAP);
        act_double  = (ev == EV_NEWTAP);
        act_release = (ev == EV_TIMEOUT);
      end
      ST_HOLD: begin
        act_timer   = (ev == EV_NEWTAP);
        act_double  = (ev == EV_NEWTAP);
        act_release = (ev == EV_FOUT) && (hold_timeout_i == 16'd0);
        act_cont    = (ev == EV_FOUT) && (hold_timeout_i != 16'd0);
      end
      ST_CONT: begin
        act_timer   = (ev == EV_NEWTAP);
        act_double  = (ev == EV_NEWTAP);
        act_release = (ev == EV_CONTTIMEOUT);
      end
      default: begin
        act_timer = 1'b0;
      end
    endcase
  end

  // Timer and edge-detect bookkeeping
  always_comb begin
    tap_start_d  = act_timer ? sample_i.now_ms : tap_start_q;
    hold_start_d = act_cont  ? sample_i.now_ms : hold_start_q;
    tap_on_d     = act_timer | (tap_on_q  & (ev != EV_TIMEOUT));
    hold_on_d    = act_cont  | (hold_on_q & (ev != EV_CONTTIMEOUT));
    prev_one_d   = (ev == EV_FIN || ev == EV_FOUT) ? sample_i.one_finger : prev_one_q;
    prev_tap_d   = active ? sample_i.single_tap : prev_tap_q;
    prev_hold_d  = active ? (sample_i.native_hold & (prev_hold_q | (ev == EV_TAPHOLD)))
                          : prev_hold_q;
  end

  // Deadlines from the state after this step; both adds run beside the event logic
  assign tap_dl  = act_timer ? (sample_i.now_ms + {16'd0, tap_timeout_i})
                             : (tap_start_q + {16'd0, tap_timeout_i});
  assign hold_dl = act_cont  ? (sample_i.now_ms + {16'd0, hold_timeout_i})
                             : (hold_start_q + {16'd0, hold_timeout_i});

  always_comb begin
    result_o.press_key           = act_press;
    result_o.release_key         = act_release;
    result_o.double_tap          = act_double;
    result_o.machine_state       = state_d;
    result_o.tap_deadline_valid  = tap_on_d;
    result_o.tap_deadline        = tap_on_d ? tap_dl : 32'd0;
    result_o.hold_deadline_valid = hold_on_d;
    result_o.hold_deadline       = hold_on_d ? hold_dl : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tap_start_q  <= 32'd0;
      hold_start_q <= 32'd0;
      prev_one_q   <= 1'b0;
      prev_tap_q   <= 1'b0;
      prev_hold_q  <= 1'b0;
      tap_on_q     <= 1'b0;
      hold_on_q    <= 1'b0;
    end else if (step_en_i) begin
      state_q      <= state_d;
      tap_start_q  <= tap_start_d;
      hold_start_q <= hold_start_d;
      prev_one_q   <= prev_one_d;
      prev_tap_q   <= prev_tap_d;
      prev_hold_q  <= prev_hold_d;
      tap_on_q     <= tap_on_d;
      hold_on_q    <= hold_on_d;
    end
  end

endmodule

### sv/touchpad_tap_hold_detector_core.sv
// Top level of the touchpad tap/hold detector: stream ports, input and result
// registers, configuration registers. Depends on tthd_pkg and tthd_engine.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream (s_axis_*): one touchpad sample per item. Master stream
//   (m_axis_*): exactly one result per sample, in order. APB port: register 0
//   (address 0) tap_timeout_ms, register 1 (address 4) hold_continue_timeout_ms,
//   both 16 bits, readable. Write configuration only while no item is in flight.
//   Path: an accepted sample waits in the input register until the result
//   register is free or draining, then steps through the engine into it.
//   Throughput: one item per cycle while m_axis_tready is high; the engine step
//   is a single pass of compare, select and add logic between the two registers.
//   Reset: machine idle, timers stopped, edge history cleared, timeouts back to
//   200 ms and 0 ms; both stream registers empty.
//   Stall: while m_axis_tready is low the result holds; the input register still
//   takes one more item, after which s_axis_tready drops until the result moves.

module touchpad_tap_hold_detector_core import tthd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: [0] single_tap, [1] native_hold, [2] one_finger, [34:3] now_ms, [39:35] zero
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InWidth-1:0]  s_axis_tdata_i,
  // tdata: [0] press_key, [1] release_key, [2] double_tap, [4:3] machine_state,
  //        [5] tap_deadline_valid, [37:6] tap_deadline, [38] hold_deadline_valid,
  //        [70:39] hold_deadline, [71] zero
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutWidth-1:0] m_axis_tdata_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic        in_vld_q, in_vld_d;
  sample_t     in_q;
  logic        out_vld_q, out_vld_d;
  result_t     out_q;
  result_t     res;
  logic        step;
  logic [15:0] tap_to_q, hold_to_q;
  logic        cfg_wr;

  // Process the held sample whenever the result register is free or draining
  assign step            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;
  assign in_vld_d        = (s_axis_tvalid_i && s_axis_tready_o) || (in_vld_q && !step);
  assign out_vld_d       = step || (out_vld_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers: capture on handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.single_tap  <= s_axis_tdata_i[0];
      in_q.native_hold <= s_axis_tdata_i[1];
      in_q.one_finger  <= s_axis_tdata_i[2];
      in_q.now_ms      <= s_axis_tdata_i[34:3];
    end
    if (step) begin
      out_q <= res;
    end
  end

  tthd_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (step),
    .sample_i       (in_q),
    .tap_timeout_i  (tap_to_q),
    .hold_timeout_i (hold_to_q),
    .result_o       (res)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0,
                            out_q.hold_deadline,
                            out_q.hold_deadline_valid,
                            out_q.tap_deadline,
                            out_q.tap_deadline_valid,
                            out_q.machine_state,
                            out_q.double_tap,
                            out_q.release_key,
                            out_q.press_key};

  // Configuration registers; word index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_to_q  <= TAP_TIMEOUT_RST;
      hold_to_q <= HOLD_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TAP_TIMEOUT) tap_to_q <= pwdata[15:0];
      else hold_to_q <= pwdata[15:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TAP_TIMEOUT:  prdata = {16'd0, tap_to_q};
      REG_HOLD_TIMEOUT: prdata = {16'd0, hold_to_q};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
